// File: src/swm_pkg.sv
// swm_pkg: shared types and constants for the sliding window maximum block
// command and status structs between controller and datapath
// no dependencies
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WIN_CFG_BITS = 7;
    localparam int SEEN_BITS    = 7;

    typedef struct packed {
        logic load;
        logic push;
        logic emit;
    } swm_cmd_t;

    typedef struct packed {
        logic result_due;
        logic out_free;
    } swm_status_t;

endpackage

// File: src/swm_ctrl.sv
// swm_ctrl: request sequencing state machine for the sliding window maximum
// depends on swm_pkg for the command and status structs
`timescale 1ns / 1ps

module swm_ctrl
    import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  swm_status_t status,
    output swm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = status.result_due ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: src/swm_datapath.sv
// swm_datapath: candidate cell row, sample history memory and output register
// depends on swm_pkg for the command and status structs
`timescale 1ns / 1ps

module swm_datapath
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  swm_cmd_t                cmd,
    output swm_status_t             status,
    input  logic [SAMPLE_BITS-1:0]  in_sample,
    input  logic                    in_first,
    input  logic                    cfg_we,
    input  logic [WIN_CFG_BITS-1:0] cfg_wdata,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [SAMPLE_BITS-1:0]  out_data
);

    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [WIN_CFG_BITS-1:0] win_reg;
    logic [WIN_CFG_BITS-1:0] k_eff;
    logic [PW-1:0]           k_m1;

    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic                    first_reg;

    logic [SAMPLE_BITS-1:0]  cells_reg [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  cells_next [MAX_WINDOW];
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;
    logic [CW-1:0]           cnt_base;
    logic [MAX_WINDOW-1:0]   keep;
    logic [CW-1:0]           tail_pos;
    logic                    full;

    logic [PW-1:0]           ptr_reg;
    logic [PW-1:0]           ptr_base;
    logic [PW-1:0]           oldest;
    logic [SEEN_BITS-1:0]    seen_reg;
    logic [SEEN_BITS-1:0]    seen_clamp;
    logic [SEEN_BITS-1:0]    seen_new;

    logic [SAMPLE_BITS-1:0]  hist_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  hist_rd_reg;
    logic                    same_slot_reg;
    logic [SAMPLE_BITS-1:0]  oldest_val;
    logic                    retire_hit;

    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_data_reg;

    // effective window: zero means one, clipped to the cell count
    always_comb
    begin
        k_eff = win_reg;
        if (win_reg == '0)
        begin
            k_eff = WIN_CFG_BITS'(1);
        end
        else if (32'(win_reg) > MAX_WINDOW)
        begin
            k_eff = WIN_CFG_BITS'(MAX_WINDOW);
        end
        k_m1 = PW'(32'(k_eff) - 32'd1);
    end

    // sequence start restarts counters
    assign cnt_base = first_reg ? '0 : cnt_reg;
    assign ptr_base = first_reg ? '0 : ptr_reg;

    always_comb
    begin
        if (ptr_base >= k_m1)
        begin
            oldest = ptr_base - k_m1;
        end
        else
        begin
            oldest = PW'(32'(ptr_base) + MAX_WINDOW - 32'(k_m1));
        end
    end

    // samples seen, clamped then counted up to the window
    always_comb
    begin
        seen_clamp = first_reg ? '0 : seen_reg;
        if (seen_clamp > k_eff)
        begin
            seen_clamp = k_eff;
        end
        seen_new = (seen_clamp < k_eff) ? seen_clamp + 1'b1 : seen_clamp;
    end

    // parallel compare against every candidate cell
    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            keep[i] = (CW'(i) < cnt_base) &&
                      ($signed(cells_reg[i]) >= $signed(sample_reg));
        end
        tail_pos = CW'(MAX_WINDOW);
        for (int i = MAX_WINDOW - 1; i >= 0; i--)
        begin
            if (!keep[i])
            begin
                tail_pos = CW'(i);
            end
        end
        full = (tail_pos == CW'(MAX_WINDOW));
    end

    assign oldest_val = same_slot_reg ? sample_reg : hist_rd_reg;
    assign retire_hit = (oldest_val == cells_reg[0]);

    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        if (cmd.push)
        begin
            if (full)
            begin
                for (int i = 0; i < MAX_WINDOW - 1; i++)
                begin
                    cells_next[i] = cells_reg[i + 1];
                end
                cells_next[MAX_WINDOW - 1] = sample_reg;
                cnt_next = CW'(MAX_WINDOW);
            end
            else
            begin
                for (int i = 0; i < MAX_WINDOW; i++)
                begin
                    if (CW'(i) == tail_pos)
                    begin
                        cells_next[i] = sample_reg;
                    end
                end
                cnt_next = tail_pos + 1'b1;
            end
        end
        else if (cmd.emit && retire_hit)
        begin
            for (int i = 0; i < MAX_WINDOW - 1; i++)
            begin
                cells_next[i] = cells_reg[i + 1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        if (cmd.load)
        begin
            sample_reg <= in_sample;
            first_reg  <= in_first;
        end
        if (cmd.emit)
        begin
            out_data_reg <= cells_reg[0];
        end
    end

    // history ring, one write and one read per request
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            hist_mem[ptr_base] <= sample_reg;
            hist_rd_reg        <= hist_mem[oldest];
            same_slot_reg      <= (oldest == ptr_base);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WIN_CFG_BITS'(1);
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_reg <= cfg_wdata;
            end
            cnt_reg <= cnt_next;
            if (cmd.push)
            begin
                ptr_reg  <= (ptr_base == PW'(MAX_WINDOW - 1)) ? '0 : ptr_base + 1'b1;
                seen_reg <= seen_new;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.result_due = (seen_new >= k_eff);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;

endmodule

// File: src/sliding_window_maximum.sv
// sliding_window_maximum: maximum of the last window_size signed samples
// usage:
//   input stream s_axis_*: tdata carries the sample, tuser marks the first
//   sample of a new sequence, which clears the window before it is taken
//   output stream m_axis_*: tdata carries the window maximum; a result is
//   produced only once window_size samples of the sequence have arrived
//   cfg_we / cfg_wdata write window_size (0 acts as 1, clipped to MAX_WINDOW)
//   while no request is in flight
// timing:
//   a request is accepted in the idle state and updated in the push state; one
//   with a result then passes the emit state, which waits for a free output
//   register, and m_axis_tvalid is registered from the emit command
// reset:
//   window_size returns to 1 and the window starts empty
// stall:
//   a pending result sits in the output register; the next request is still
//   accepted and updated, and its result waits until m_axis_tready frees it
// depends on swm_pkg, swm_ctrl and swm_datapath
`timescale 1ns / 1ps

module sliding_window_maximum
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // sample
    input  logic                               s_axis_tuser,  // first
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,  // window_max
    input  logic                               cfg_we,
    input  logic [WIN_CFG_BITS-1:0]            cfg_wdata
);

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;

    swm_cmd_t               cmd;
    swm_status_t            status;
    logic [SAMPLE_BITS-1:0] out_data;

    swm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_first  (s_axis_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data)
    );

    assign m_axis_tdata = TDW'(out_data);

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.push, cmd.emit}))
        else $error("controller issued overlapping commands");

    a_load_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.push && !s_axis_tready)
        else $error("accepted request not followed by update");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted over a pending result");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_axis_tvalid && s_axis_tready)
        else $error("emitted result not presented");

endmodule
